[rtl/core/tfn_pkg.sv]
// tfn_pkg: shared constants, beat types and helpers for the face normal unit.
// No dependencies; every module of the block but tfn_ram imports it.
package tfn_pkg;

    // Vertex store geometry
    localparam int VERTEX_COUNT = 1024;
    localparam int ADDR_W       = $clog2(VERTEX_COUNT);
    localparam int IDX_W        = 10;
    localparam int COORD_W      = 16;
    localparam int VTX_W        = 3 * COORD_W;

    // Cross product datapath widths
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = PROD_W;
    localparam int HALF_W  = MAG_W / 2;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 2;

    // Normaliser widths: one result bit per step
    localparam int K_W    = 15;
    localparam int NORM_W = 16;
    localparam int L_SH   = 2 * K_W;
    localparam int ACC_W  = SUM_W + 2 * (K_W + 1) + 2;
    localparam int BACC_W = SUM_W + K_W + 3;
    localparam int ITER_W = $clog2(K_W);
    localparam int SH_W   = $clog2(L_SH + 1);

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TRI  = 1'b1;

    typedef struct packed {
        logic                      cmd;
        logic [IDX_W-1:0]          vertex_index;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [IDX_W-1:0]          corner_a;
        logic [IDX_W-1:0]          corner_b;
        logic [IDX_W-1:0]          corner_c;
    } tfn_in_t;

    typedef struct packed {
        logic signed [NORM_W-1:0] normal_x;
        logic signed [NORM_W-1:0] normal_y;
        logic signed [NORM_W-1:0] normal_z;
        logic                     degenerate;
        logic [IDX_W-1:0]         echo_a;
        logic [IDX_W-1:0]         echo_b;
        logic [IDX_W-1:0]         echo_c;
    } tfn_out_t;

    // Store word layout: x low, z high
    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } tfn_vtx_t;

    // Face handed from the cross product front end to the normaliser
    typedef struct packed {
        logic [2:0]            neg;
        logic [2:0][SQ_W-1:0]  sq;
        logic [SUM_W-1:0]      s;
        logic [2:0][IDX_W-1:0] corner;
    } tfn_face_t;

    typedef enum logic [3:0] {
        F_IDLE,
        F_RD_B,
        F_RD_C,
        F_CAP2,
        F_DIFF,
        F_MUL,
        F_CROSS,
        F_PART,
        F_SQR,
        F_SUM
    } tfn_front_state_t;

    typedef enum logic [1:0] {
        N_IDLE,
        N_RUN,
        N_DONE
    } tfn_norm_state_t;

    function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
        return (32'(idx) < VERTEX_COUNT);
    endfunction

    function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
        return ADDR_W'(idx);
    endfunction

endpackage

[rtl/core/triangle_face_normal.sv]
// triangle_face_normal: flat-shading face normal unit, top level.
// Depends on tfn_pkg, tfn_ram, tfn_front and tfn_norm.
//
//   channel  | beat type  | handshake
//   ---------+------------+----------------------------------
//   item     | tfn_in_t   | item_valid / item_stall   (in)
//   result   | tfn_out_t  | result_valid / result_stall (out)
//
// A load beat is taken every cycle except while the single store port reads
// the other two corners of a triangle beat (states F_RD_B and F_RD_C).
// A triangle's face then passes the states F_CAP2 to F_SUM and is handed to
// the normaliser, which finds one result bit per step. A new triangle beat is
// taken once the front end is idle and its last face has been handed over.
// Reset clears control state only; the vertex store is undefined until written.
// A stalled result holds in the output register while the next triangle works.
module triangle_face_normal import tfn_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    input  tfn_in_t  item,
    output logic     result_valid,
    input  logic     result_stall,
    output tfn_out_t result
);

    logic              ram_en, ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [VTX_W-1:0]  ram_wdata, ram_rdata;
    logic              face_valid, face_take;
    tfn_face_t         face;
    logic              done_valid, done_take;
    tfn_out_t          done;

    logic     out_valid_reg, out_valid_next;
    tfn_out_t out_reg;

    tfn_ram #(
        .WIDTH (VTX_W),
        .DEPTH (VERTEX_COUNT)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    tfn_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .ram_en     (ram_en),
        .ram_we     (ram_we),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata),
        .ram_rdata  (ram_rdata),
        .face_valid (face_valid),
        .face       (face),
        .face_take  (face_take)
    );

    tfn_norm u_norm (
        .clk        (clk),
        .rst_n      (rst_n),
        .face_valid (face_valid),
        .face       (face),
        .face_take  (face_take),
        .done_valid (done_valid),
        .done       (done),
        .done_take  (done_take)
    );

    // Output register: refills as the previous beat leaves
    always_comb
    begin
        done_take = !out_valid_reg || !result_stall;
        priority if (done_valid && done_take)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (done_valid && done_take)
            out_reg <= done;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

[rtl/core/tfn_ram.sv]
// tfn_ram: generic single-port synchronous RAM, registered read.
// No dependencies.
module tfn_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One access per cycle: write, or read into the output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata <= mem[addr];
        end
    end

endmodule

[rtl/core/tfn_front.sv]
// tfn_front: input beat handling, vertex fetch and cross product / square sum.
// Depends on tfn_pkg; drives the port of the vertex store RAM.
module tfn_front import tfn_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  tfn_in_t           item,
    output logic              ram_en,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_addr,
    output logic [VTX_W-1:0]  ram_wdata,
    input  logic [VTX_W-1:0]  ram_rdata,
    output logic              face_valid,
    output tfn_face_t         face,
    input  logic              face_take
);

    tfn_front_state_t state_reg, state_next;
    logic             face_valid_reg, face_valid_next;
    logic             ram_busy, accept, tri_go, load_go;

    logic [2:0][IDX_W-1:0]            corner_reg;
    logic [2:0]                       oor_reg;
    tfn_vtx_t [2:0]                   p_reg;
    logic signed [DIFF_W-1:0]         d1_reg [3];
    logic signed [DIFF_W-1:0]         d2_reg [3];
    logic signed [PROD_W-1:0]         prod_reg [6];
    logic [2:0][MAG_W-1:0]            mag_reg;
    logic [2:0]                       neg_reg;
    logic [2:0][PROD_W-1:0]           hh_reg, hl_reg, ll_reg;
    logic [2:0][SQ_W-1:0]             sq_reg;
    logic [SUM_W-1:0]                 s_reg;
    logic signed [CROSS_W-1:0]        cross_val [3];
    logic [2:0][MAG_W-1:0]            mag;
    tfn_vtx_t                         rd_vtx;

    // Handshake: the port is busy for the second and third corner reads
    always_comb
    begin
        ram_busy   = (state_reg == F_RD_B) || (state_reg == F_RD_C);
        item_stall = ram_busy ||
                     ((item.cmd == CMD_TRI) && ((state_reg != F_IDLE) || face_valid_reg));
        accept     = item_valid && !item_stall;
        tri_go     = accept && (item.cmd == CMD_TRI);
        load_go    = accept && (item.cmd == CMD_LOAD);
    end

    // Store port arbitration
    always_comb
    begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = to_addr(item.vertex_index);
        ram_wdata = {item.pos_z, item.pos_y, item.pos_x};
        priority if (ram_busy)
        begin
            ram_en   = 1'b1;
            ram_addr = (state_reg == F_RD_B) ? to_addr(corner_reg[1]) : to_addr(corner_reg[2]);
        end
        else if (load_go)
        begin
            ram_en = idx_ok(item.vertex_index);
            ram_we = 1'b1;
        end
        else if (tri_go)
        begin
            ram_en   = 1'b1;
            ram_addr = to_addr(item.corner_a);
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        face_valid_next = face_valid_reg;
        unique case (state_reg)
            F_IDLE:  if (tri_go) state_next = F_RD_B;
            F_RD_B:  state_next = F_RD_C;
            F_RD_C:  state_next = F_CAP2;
            F_CAP2:  state_next = F_DIFF;
            F_DIFF:  state_next = F_MUL;
            F_MUL:   state_next = F_CROSS;
            F_CROSS: state_next = F_PART;
            F_PART:  state_next = F_SQR;
            F_SQR:   state_next = F_SUM;
            F_SUM:   state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
        if (state_reg == F_SUM)
            face_valid_next = 1'b1;
        else if (face_take)
            face_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            face_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            face_valid_reg <= face_valid_next;
        end
    end

    // Cross product and magnitude from the product registers
    always_comb
    begin
        rd_vtx = tfn_vtx_t'(ram_rdata);
        for (int j = 0; j < 3; j++)
        begin
            cross_val[j] = CROSS_W'(prod_reg[2*j]) - CROSS_W'(prod_reg[2*j+1]);
            mag[j]       = cross_val[j][CROSS_W-1] ? MAG_W'(-cross_val[j])
                                                   : MAG_W'(cross_val[j]);
        end
    end

    // Datapath registers, one step per sequencer state
    always_ff @(posedge clk)
    begin
        if (tri_go)
        begin
            corner_reg <= {item.corner_c, item.corner_b, item.corner_a};
            oor_reg    <= {!idx_ok(item.corner_c), !idx_ok(item.corner_b),
                           !idx_ok(item.corner_a)};
        end
        if (state_reg == F_RD_B)
            p_reg[0] <= oor_reg[0] ? '0 : rd_vtx;
        if (state_reg == F_RD_C)
            p_reg[1] <= oor_reg[1] ? '0 : rd_vtx;
        if (state_reg == F_CAP2)
            p_reg[2] <= oor_reg[2] ? '0 : rd_vtx;
        if (state_reg == F_DIFF)
        begin
            d1_reg[0] <= DIFF_W'(p_reg[1].x) - DIFF_W'(p_reg[0].x);
            d1_reg[1] <= DIFF_W'(p_reg[1].y) - DIFF_W'(p_reg[0].y);
            d1_reg[2] <= DIFF_W'(p_reg[1].z) - DIFF_W'(p_reg[0].z);
            d2_reg[0] <= DIFF_W'(p_reg[2].x) - DIFF_W'(p_reg[0].x);
            d2_reg[1] <= DIFF_W'(p_reg[2].y) - DIFF_W'(p_reg[0].y);
            d2_reg[2] <= DIFF_W'(p_reg[2].z) - DIFF_W'(p_reg[0].z);
        end
        if (state_reg == F_MUL)
        begin
            prod_reg[0] <= d1_reg[1] * d2_reg[2];
            prod_reg[1] <= d1_reg[2] * d2_reg[1];
            prod_reg[2] <= d1_reg[2] * d2_reg[0];
            prod_reg[3] <= d1_reg[0] * d2_reg[2];
            prod_reg[4] <= d1_reg[0] * d2_reg[1];
            prod_reg[5] <= d1_reg[1] * d2_reg[0];
        end
        if (state_reg == F_CROSS)
        begin
            for (int j = 0; j < 3; j++)
            begin
                mag_reg[j] <= mag[j];
                neg_reg[j] <= cross_val[j][CROSS_W-1];
            end
        end
        // Square split into half-width partial products
        if (state_reg == F_PART)
        begin
            for (int j = 0; j < 3; j++)
            begin
                hh_reg[j] <= mag_reg[j][MAG_W-1:HALF_W] * mag_reg[j][MAG_W-1:HALF_W];
                hl_reg[j] <= mag_reg[j][MAG_W-1:HALF_W] * mag_reg[j][HALF_W-1:0];
                ll_reg[j] <= mag_reg[j][HALF_W-1:0] * mag_reg[j][HALF_W-1:0];
            end
        end
        if (state_reg == F_SQR)
        begin
            for (int j = 0; j < 3; j++)
                sq_reg[j] <= (SQ_W'(hh_reg[j]) << (2 * HALF_W))
                           + (SQ_W'(hl_reg[j]) << (HALF_W + 1))
                           + SQ_W'(ll_reg[j]);
        end
        if (state_reg == F_SUM)
            s_reg <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
    end

    assign face_valid  = face_valid_reg;
    assign face.neg    = neg_reg;
    assign face.sq     = sq_reg;
    assign face.s      = s_reg;
    assign face.corner = corner_reg;

    // Corner reads never collide with a vertex write
    a_port_free: assert property (@(posedge clk) disable iff (!rst_n)
        ram_busy |-> !ram_we)
        else $error("store write during corner fetch");

    a_tri_start: assert property (@(posedge clk) disable iff (!rst_n)
        tri_go |=> (state_reg == F_RD_B))
        else $error("triangle beat did not start the fetch");

    a_face_hold: assert property (@(posedge clk) disable iff (!rst_n)
        face_valid_reg |-> (state_reg == F_IDLE))
        else $error("front end busy while a face waits");

endmodule

[rtl/core/tfn_norm.sv]
// tfn_norm: iterative normaliser, one result bit per cycle for all three axes.
// Depends on tfn_pkg; takes faces from tfn_front.
module tfn_norm import tfn_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      face_valid,
    input  tfn_face_t face,
    output logic      face_take,
    output logic      done_valid,
    output tfn_out_t  done,
    input  logic      done_take
);

    tfn_norm_state_t state_reg, state_next;
    logic [ITER_W-1:0] iter_reg;

    logic [2:0][ACC_W-1:0]  l_reg, a_reg;
    logic [2:0][BACC_W-1:0] b_reg;
    logic [2:0][K_W-1:0]    k_reg;
    logic [2:0]             neg_reg;
    logic [SUM_W-1:0]       s_reg;
    logic                   deg_reg;
    logic [2:0][IDX_W-1:0]  corner_reg;

    logic [SH_W-1:0]        sh_1, sh_b, sh_s;
    logic [2:0][ACC_W-1:0]  a_new, t_val;
    logic [2:0][BACC_W-1:0] b_new;
    logic [2:0]             hit;
    logic [2:0][NORM_W-1:0] comp;

    assign face_take  = (state_reg == N_IDLE) && face_valid;
    assign done_valid = (state_reg == N_DONE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            N_IDLE: if (face_valid)
                        state_next = (face.s == '0) ? N_DONE : N_RUN;
            N_RUN:  if (iter_reg == '0) state_next = N_DONE;
            N_DONE: if (done_take) state_next = N_IDLE;
            default: state_next = N_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= N_IDLE;
        else
            state_reg <= state_next;
    end

    // Trial of bit iter: w grows by d = 2^(iter+1), test (w-1)^2 s against 2^30 c^2
    always_comb
    begin
        sh_1 = SH_W'(iter_reg) + SH_W'(1);
        sh_b = SH_W'(iter_reg) + SH_W'(2);
        sh_s = SH_W'(sh_1) << 1;
        for (int i = 0; i < 3; i++)
        begin
            a_new[i] = a_reg[i] + (ACC_W'(b_reg[i]) << sh_b) + (ACC_W'(s_reg) << sh_s);
            b_new[i] = b_reg[i] + (BACC_W'(s_reg) << sh_1);
            t_val[i] = a_new[i] - (ACC_W'(b_new[i]) << 1) + ACC_W'(s_reg);
            hit[i]   = (t_val[i] <= l_reg[i]);
            comp[i]  = neg_reg[i] ? (NORM_W'(0) - NORM_W'(k_reg[i])) : NORM_W'(k_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (face_take)
        begin
            for (int i = 0; i < 3; i++)
            begin
                l_reg[i] <= ACC_W'(face.sq[i]) << L_SH;
                a_reg[i] <= '0;
                b_reg[i] <= '0;
                k_reg[i] <= '0;
            end
            neg_reg    <= face.neg;
            s_reg      <= face.s;
            deg_reg    <= (face.s == '0);
            corner_reg <= face.corner;
            iter_reg   <= ITER_W'(K_W - 1);
        end
        else if (state_reg == N_RUN)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (hit[i])
                begin
                    a_reg[i]           <= a_new[i];
                    b_reg[i]           <= b_new[i];
                    k_reg[i][iter_reg] <= 1'b1;
                end
            end
            iter_reg <= iter_reg - ITER_W'(1);
        end
    end

    assign done.normal_x   = comp[0];
    assign done.normal_y   = comp[1];
    assign done.normal_z   = comp[2];
    assign done.degenerate = deg_reg;
    assign done.echo_a     = corner_reg[0];
    assign done.echo_b     = corner_reg[1];
    assign done.echo_c     = corner_reg[2];

    a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == N_RUN) && (iter_reg == '0) |=> (state_reg == N_DONE))
        else $error("normaliser ran past its last bit");

    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == N_DONE) && !done_take |=> (state_reg == N_DONE) && $stable(k_reg))
        else $error("normal lost before hand-off");

endmodule
